// ===== sv/ced_pkg.sv =====
// Shared types and constants for the capped edit distance unit.
// No dependencies; used by ced_cell and capped_edit_distance_unit.
`timescale 1ns / 1ps

package ced_pkg;

  localparam int MODE_W     = 2;
  localparam int CH_W       = 8;
  localparam int LIMIT_W    = 6;
  localparam int DIST_W     = 7;
  localparam int IN_W       = 16;  // ch + limit, padded to whole bytes
  localparam int IN_USER_W  = 2;   // mode
  localparam int OUT_W      = 8;   // distance, padded to whole bytes
  localparam int OUT_USER_W = 1;   // truncated

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND_A = 2'd0,
    MODE_APPEND_B = 2'd1,
    MODE_COMPUTE  = 2'd2,
    MODE_UNUSED   = 2'd3
  } mode_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_START  = 6'b000010,
    ST_ROW    = 6'b000100,
    ST_CELL   = 6'b001000,
    ST_ROWEND = 6'b010000,
    ST_FIN    = 6'b100000
  } state_t;

endpackage

// ===== sv/ced_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ced_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ced_cell.sv =====
// One dynamic-programming cell: min(up+1, left+1, diag+mismatch).
// Depends on ced_pkg for the character width.
`timescale 1ns / 1ps

module ced_cell #(
  parameter int LW = 6
) (
  input  logic [LW-1:0]            up,
  input  logic [LW-1:0]            diag,
  input  logic [LW-1:0]            left,
  input  logic [ced_pkg::CH_W-1:0] ch_a,
  input  logic [ced_pkg::CH_W-1:0] ch_b,
  output logic [LW-1:0]            cost
);

  logic [LW:0] up_inc;
  logic [LW:0] left_inc;
  logic [LW:0] sub;
  logic [LW:0] m1;
  logic [LW:0] m2;

  always_comb begin
    up_inc   = {1'b0, up} + {{LW{1'b0}}, 1'b1};
    left_inc = {1'b0, left} + {{LW{1'b0}}, 1'b1};
    sub      = {1'b0, diag} + {{LW{1'b0}}, (ch_a != ch_b)};
    m1       = (up_inc < left_inc) ? up_inc : left_inc;
    m2       = (m1 < sub) ? m1 : sub;
    // a cell never exceeds the longer prefix length, so the top bit is zero
    cost     = m2[LW-1:0];
  end

endmodule

// ===== sv/capped_edit_distance_unit.sv =====
// Capped Levenshtein distance: string stores, row store, sequencer and output register.
// Depends on ced_pkg, ced_ram and ced_cell.
//
//   channel | dir | tdata (low bit first)     | tuser        | moves
//   s_axis  | in  | ch[7:0] limit[13:8]       | mode[1:0]    | one load or compute transfer
//   m_axis  | out | distance[6:0]             | truncated[0] | one result per compute
//
// Load transfers are accepted while idle. After a compute transfer tready stays low
// through one start state, per row a setup state, one cell state per character of the
// second string and a row-end check, then a finish state; the single shared cell unit
// visits one cell per cycle against the row RAM. The length cutoff or an empty first
// string skips the walk; a row-minimum cutoff ends it at that row end.
// Reset clears lengths, the overflow flag, the sequencer and the output valid.
// The result waits in the output register; a new compute finishes only
// after the previous result has been taken.
`timescale 1ns / 1ps

module capped_edit_distance_unit #(
  parameter int MAX_LEN = 63
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ced_pkg::IN_W-1:0]       s_axis_tdata,   // ch, limit
  input  logic [ced_pkg::IN_USER_W-1:0]  s_axis_tuser,   // mode
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [ced_pkg::OUT_W-1:0]      m_axis_tdata,   // distance
  output logic [ced_pkg::OUT_USER_W-1:0] m_axis_tuser    // truncated
);

  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int SAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW  = (LW > ced_pkg::DIST_W) ? LW : ced_pkg::DIST_W;
  localparam int DW  = ced_pkg::DIST_W;

  ced_pkg::state_t state;

  logic [ced_pkg::MODE_W-1:0]  in_mode;
  logic [ced_pkg::CH_W-1:0]    in_ch;
  logic [ced_pkg::LIMIT_W-1:0] in_limit;
  logic                        in_xfer;
  logic                        out_free;

  logic [LW-1:0] la;
  logic [LW-1:0] lb;
  logic          ovf;
  logic [ced_pkg::LIMIT_W-1:0] lim;
  logic [LW-1:0] i;
  logic [LW-1:0] j;
  logic [LW-1:0] diag;
  logic [LW-1:0] left;
  logic [LW-1:0] row_min;
  logic          first_row;
  logic [ced_pkg::DIST_W-1:0] res;

  logic [ced_pkg::DIST_W-1:0] lim_plus;
  logic [LW-1:0] diff;
  logic [LW-1:0] up;
  logic [LW-1:0] cost;

  logic [SAW-1:0]          a_raddr;
  logic [SAW-1:0]          b_raddr;
  logic [LW-1:0]           row_raddr;
  logic [ced_pkg::CH_W-1:0] a_rd;
  logic [ced_pkg::CH_W-1:0] b_rd;
  logic [LW-1:0]           row_rd;
  logic                    a_we;
  logic                    b_we;
  logic                    row_we;

  assign in_mode  = s_axis_tuser[ced_pkg::MODE_W-1:0];
  assign in_ch    = s_axis_tdata[ced_pkg::CH_W-1:0];
  assign in_limit = s_axis_tdata[ced_pkg::CH_W +: ced_pkg::LIMIT_W];

  assign s_axis_tready = (state == ced_pkg::ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign a_we = in_xfer && (in_mode == ced_pkg::MODE_APPEND_A) && (la < LW'(MAX_LEN));
  assign b_we = in_xfer && (in_mode == ced_pkg::MODE_APPEND_B) && (lb < LW'(MAX_LEN));

  assign lim_plus = {1'b0, lim} + {{(ced_pkg::DIST_W-1){1'b0}}, 1'b1};
  assign diff     = (la > lb) ? (la - lb) : (lb - la);

  // row i-1 reads from the store, except the first row which is 0..lb
  assign up = first_row ? j : row_rd;

  // prime reads in ROW for cell 1, then run one cell ahead
  assign a_raddr   = SAW'(i - {{(LW-1){1'b0}}, 1'b1});
  assign b_raddr   = (state == ced_pkg::ST_CELL) ? SAW'(j) : '0;
  assign row_raddr = (state == ced_pkg::ST_CELL) ? (j + {{(LW-1){1'b0}}, 1'b1})
                                                 : {{(LW-1){1'b0}}, 1'b1};
  assign row_we    = (state == ced_pkg::ST_CELL);

  ced_ram #(.WIDTH(ced_pkg::CH_W), .DEPTH(MAX_LEN)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (SAW'(la)),
    .wdata (in_ch),
    .raddr (a_raddr),
    .rdata (a_rd)
  );

  ced_ram #(.WIDTH(ced_pkg::CH_W), .DEPTH(MAX_LEN)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (SAW'(lb)),
    .wdata (in_ch),
    .raddr (b_raddr),
    .rdata (b_rd)
  );

  ced_ram #(.WIDTH(LW), .DEPTH(MAX_LEN + 1)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (j),
    .wdata (cost),
    .raddr (row_raddr),
    .rdata (row_rd)
  );

  ced_cell #(.LW(LW)) u_cell (
    .up   (up),
    .diag (diag),
    .left (left),
    .ch_a (a_rd),
    .ch_b (b_rd),
    .cost (cost)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ced_pkg::ST_IDLE;
      la            <= '0;
      lb            <= '0;
      ovf           <= 1'b0;
      m_axis_tvalid <= 1'b0;
      first_row     <= 1'b0;
    end else begin
      if ((state == ced_pkg::ST_FIN) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ced_pkg::ST_IDLE: begin
          if (in_xfer) begin
            case (in_mode)
              ced_pkg::MODE_APPEND_A: begin
                if (a_we) la <= la + {{(LW-1){1'b0}}, 1'b1};
                else      ovf <= 1'b1;
              end
              ced_pkg::MODE_APPEND_B: begin
                if (b_we) lb <= lb + {{(LW-1){1'b0}}, 1'b1};
                else      ovf <= 1'b1;
              end
              ced_pkg::MODE_COMPUTE: begin
                lim   <= in_limit;
                state <= ced_pkg::ST_START;
              end
              default: begin
              end
            endcase
          end
        end
        ced_pkg::ST_START: begin
          if (CW'(diff) > CW'(lim)) begin
            res   <= lim_plus;
            state <= ced_pkg::ST_FIN;
          end else if (la == '0) begin
            res   <= DW'(lb);
            state <= ced_pkg::ST_FIN;
          end else begin
            i         <= {{(LW-1){1'b0}}, 1'b1};
            first_row <= 1'b1;
            state     <= ced_pkg::ST_ROW;
          end
        end
        ced_pkg::ST_ROW: begin
          diag    <= i - {{(LW-1){1'b0}}, 1'b1};
          left    <= i;
          row_min <= i;
          j       <= {{(LW-1){1'b0}}, 1'b1};
          state   <= (lb == '0) ? ced_pkg::ST_ROWEND : ced_pkg::ST_CELL;
        end
        ced_pkg::ST_CELL: begin
          diag    <= up;
          left    <= cost;
          row_min <= (cost < row_min) ? cost : row_min;
          j       <= j + {{(LW-1){1'b0}}, 1'b1};
          if (j == lb) state <= ced_pkg::ST_ROWEND;
        end
        ced_pkg::ST_ROWEND: begin
          if (CW'(row_min) > CW'(lim)) begin
            res   <= lim_plus;
            state <= ced_pkg::ST_FIN;
          end else if (i == la) begin
            res   <= (CW'(left) > CW'(lim)) ? lim_plus : DW'(left);
            state <= ced_pkg::ST_FIN;
          end else begin
            i         <= i + {{(LW-1){1'b0}}, 1'b1};
            first_row <= 1'b0;
            state     <= ced_pkg::ST_ROW;
          end
        end
        ced_pkg::ST_FIN: begin
          // hold until the output register is free, then clear the pair
          if (out_free) begin
            m_axis_tdata  <= {{(ced_pkg::OUT_W-ced_pkg::DIST_W){1'b0}}, res};
            m_axis_tuser  <= ovf;
            la            <= '0;
            lb            <= '0;
            ovf           <= 1'b0;
            state         <= ced_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= ced_pkg::ST_IDLE;
        end
      endcase
    end
  end

  a_cell_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ced_pkg::ST_CELL) |-> (j != '0 && j <= lb))
    else $error("cell column outside second string");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ced_pkg::ST_ROW) |-> (i != '0 && i <= la))
    else $error("row index outside first string");

  a_row_min_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ced_pkg::ST_CELL) |-> (row_min <= i))
    else $error("row minimum above column-zero value");

  a_result_capped: assert property (@(posedge clk) disable iff (rst)
    (state == ced_pkg::ST_FIN) |-> (res <= lim_plus))
    else $error("result above limit plus one");

endmodule
